// File: src/llq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_pkg
// Shared types and codes for the linked-list queue with free stack.
// ----------------------------------------------------------------------------
package llq_pkg;

  // pool size is fixed by the 6-bit node fields on both streams
  localparam int POOL_NODES = 64;

  typedef enum logic [2:0] {
    FN_ALLOC = 3'd0,
    FN_ENQ   = 3'd1,
    FN_DEQ   = 3'd2,
    FN_SET   = 3'd3,
    FN_READ  = 3'd4,
    FN_FREE  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_INIT     = 3'd1,
    ST_DOING    = 3'd2,
    ST_DONE     = 3'd3,
    ST_CONSUMED = 3'd4,
    ST_CRASH    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_EXHAUSTED = 2'd1,
    RES_EMPTY     = 2'd2,
    RES_BLOCKED   = 2'd3
  } res_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_RD_STATUS,
    S_ENQ_LINK,
    S_DQ_RING,
    S_DQ_EVST,
    S_DQ_LINK,
    S_DQ_STAT,
    S_DQ_FREE,
    S_RESULT
  } state_e;

  typedef struct packed {
    res_e        code;
    logic [5:0]  node;
    logic [2:0]  status;
    logic [31:0] payload;
  } llq_result_t;

  typedef struct packed {
    logic link;
    logic status;
    logic payload;
  } llq_mem_we_t;

endpackage
`default_nettype wire

// File: src/llq_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_node_mem
// Node pool storage: link, status and payload arrays, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module llq_node_mem
  import llq_pkg::*;
(
  input  wire                                  clk_i,
  input  llq_mem_we_t                          we_i,
  input  wire [$clog2(POOL_NODES)-1:0]         link_waddr_i,
  input  wire [$clog2(POOL_NODES+1)-1:0]       link_wdata_i,
  input  wire [$clog2(POOL_NODES)-1:0]         status_waddr_i,
  input  wire [2:0]                            status_wdata_i,
  input  wire [$clog2(POOL_NODES)-1:0]         payload_waddr_i,
  input  wire [31:0]                           payload_wdata_i,
  input  wire [$clog2(POOL_NODES)-1:0]         link_raddr_i,
  input  wire [$clog2(POOL_NODES)-1:0]         status_raddr_i,
  input  wire [$clog2(POOL_NODES)-1:0]         payload_raddr_i,
  output logic [$clog2(POOL_NODES+1)-1:0]      link_rdata_o,
  output logic [2:0]                           status_rdata_o,
  output logic [31:0]                          payload_rdata_o
);

  localparam int LW = $clog2(POOL_NODES + 1);

  logic [LW-1:0] link_mem    [POOL_NODES];
  logic [2:0]    status_mem  [POOL_NODES];
  logic [31:0]   payload_mem [POOL_NODES];

  logic [LW-1:0] link_rdata_q;
  logic [2:0]    status_rdata_q;
  logic [31:0]   payload_rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.link) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rdata_q <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.status) begin
      status_mem[status_waddr_i] <= status_wdata_i;
    end
    status_rdata_q <= status_mem[status_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.payload) begin
      payload_mem[payload_waddr_i] <= payload_wdata_i;
    end
    payload_rdata_q <= payload_mem[payload_raddr_i];
  end

  assign link_rdata_o    = link_rdata_q;
  assign status_rdata_o  = status_rdata_q;
  assign payload_rdata_o = payload_rdata_q;

endmodule
`default_nettype wire

// File: src/llq_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_ring_mem
// Deferred-free ring of retired sentinels, one write and one registered
// read port.
// ----------------------------------------------------------------------------
module llq_ring_mem
  import llq_pkg::*;
#(
  parameter int RETIRE_DEPTH = 16
) (
  input  wire                                                   clk_i,
  input  wire                                                   we_i,
  input  wire [(RETIRE_DEPTH > 1 ? $clog2(RETIRE_DEPTH) : 1)-1:0] waddr_i,
  input  wire [$clog2(POOL_NODES+1)-1:0]                        wdata_i,
  input  wire [(RETIRE_DEPTH > 1 ? $clog2(RETIRE_DEPTH) : 1)-1:0] raddr_i,
  output logic [$clog2(POOL_NODES+1)-1:0]                       rdata_o
);

  localparam int LW = $clog2(POOL_NODES + 1);

  logic [LW-1:0] ring_mem [RETIRE_DEPTH];
  logic [LW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ring_mem[waddr_i] <= wdata_i;
    end
    rdata_q <= ring_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/llq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llq_ctrl
// Sequencer for the queue manager: decodes one request, walks the chain one
// link per step through the shared memory ports and commits the result.
// ----------------------------------------------------------------------------
module llq_ctrl
  import llq_pkg::*;
#(
  parameter int RETIRE_DEPTH = 16
) (
  input  wire                                                    clk_i,
  input  wire                                                    rst_ni,
  input  wire                                                    in_valid_i,
  output logic                                                   in_ready_o,
  input  wire [2:0]                                              in_func_i,
  input  wire [5:0]                                              in_node_i,
  input  wire [2:0]                                              in_status_i,
  input  wire [31:0]                                             in_payload_i,
  output logic                                                   res_valid_o,
  input  wire                                                    res_ready_i,
  output llq_result_t                                            res_o,
  output llq_mem_we_t                                            mem_we_o,
  output logic [$clog2(POOL_NODES)-1:0]                          link_waddr_o,
  output logic [$clog2(POOL_NODES+1)-1:0]                        link_wdata_o,
  output logic [$clog2(POOL_NODES)-1:0]                          status_waddr_o,
  output logic [2:0]                                             status_wdata_o,
  output logic [$clog2(POOL_NODES)-1:0]                          payload_waddr_o,
  output logic [31:0]                                            payload_wdata_o,
  output logic [$clog2(POOL_NODES)-1:0]                          link_raddr_o,
  output logic [$clog2(POOL_NODES)-1:0]                          status_raddr_o,
  output logic [$clog2(POOL_NODES)-1:0]                          payload_raddr_o,
  input  wire [$clog2(POOL_NODES+1)-1:0]                         link_rdata_i,
  input  wire [2:0]                                              status_rdata_i,
  input  wire [31:0]                                             payload_rdata_i,
  output logic                                                   ring_we_o,
  output logic [(RETIRE_DEPTH > 1 ? $clog2(RETIRE_DEPTH) : 1)-1:0] ring_waddr_o,
  output logic [$clog2(POOL_NODES+1)-1:0]                        ring_wdata_o,
  output logic [(RETIRE_DEPTH > 1 ? $clog2(RETIRE_DEPTH) : 1)-1:0] ring_raddr_o,
  input  wire [$clog2(POOL_NODES+1)-1:0]                         ring_rdata_i
);

  localparam int NW      = $clog2(POOL_NODES);
  localparam int LW      = $clog2(POOL_NODES + 1);
  localparam int RW      = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
  localparam int STEPS   = 2 * POOL_NODES + 2;
  localparam int SW      = $clog2(STEPS + 1);
  localparam int CLR_LEN = (POOL_NODES > RETIRE_DEPTH) ? POOL_NODES : RETIRE_DEPTH;
  localparam int CLW     = $clog2(CLR_LEN);

  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_NODES);
  localparam logic [SW-1:0] STEP_MAX  = SW'(STEPS);

  state_e        state_q, state_d;
  logic [NW-1:0] head_q, head_d;
  logic [NW-1:0] tail_q, tail_d;
  logic [LW-1:0] free_top_q, free_top_d;
  logic [RW-1:0] pos_q, pos_d;
  logic [CLW-1:0] clr_q, clr_d;

  logic [NW-1:0] wh_q, wh_d;
  logic [NW-1:0] wt_q, wt_d;
  logic [NW-1:0] nxt_q, nxt_d;
  logic [NW-1:0] node_q, node_d;
  logic [LW-1:0] evict_q, evict_d;
  logic          evict_ok_q, evict_ok_d;
  logic [SW-1:0] steps_q, steps_d;
  llq_result_t   res_q, res_d;

  logic          node_in_ok;
  logic [NW-1:0] node_idx;
  logic          nxt_ok;
  logic [NW-1:0] nxt_idx;
  logic          evict_valid;
  logic [SW-1:0] steps_inc;
  logic [RW-1:0] pos_inc;

  assign node_in_ok  = int'(in_node_i) < POOL_NODES;
  assign node_idx    = NW'(in_node_i);
  assign nxt_ok      = link_rdata_i < LINK_NULL;
  assign nxt_idx     = NW'(link_rdata_i);
  assign evict_valid = evict_q < LINK_NULL;
  assign steps_inc   = steps_q + 1'b1;
  assign pos_inc     = (int'(pos_q) == RETIRE_DEPTH - 1) ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      head_q     <= '0;
      tail_q     <= '0;
      free_top_q <= LW'(1);
      pos_q      <= '0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      free_top_q <= free_top_d;
      pos_q      <= pos_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wh_q       <= wh_d;
    wt_q       <= wt_d;
    nxt_q      <= nxt_d;
    node_q     <= node_d;
    evict_q    <= evict_d;
    evict_ok_q <= evict_ok_d;
    steps_q    <= steps_d;
    res_q      <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    free_top_d = free_top_q;
    pos_d      = pos_q;
    clr_d      = clr_q;
    wh_d       = wh_q;
    wt_d       = wt_q;
    nxt_d      = nxt_q;
    node_d     = node_q;
    evict_d    = evict_q;
    evict_ok_d = evict_ok_q;
    steps_d    = steps_q;
    res_d      = res_q;

    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;
    mem_we_o        = '0;
    link_waddr_o    = '0;
    link_wdata_o    = '0;
    status_waddr_o  = '0;
    status_wdata_o  = '0;
    payload_waddr_o = '0;
    payload_wdata_o = '0;
    link_raddr_o    = '0;
    status_raddr_o  = '0;
    payload_raddr_o = '0;
    ring_we_o       = 1'b0;
    ring_waddr_o    = '0;
    ring_wdata_o    = '0;
    ring_raddr_o    = '0;

    case (state_q)
      // rebuild the free chain and the null ring, one entry a cycle
      S_CLEAR: begin
        if (int'(clr_q) < POOL_NODES) begin
          mem_we_o.link   = 1'b1;
          mem_we_o.status = 1'b1;
          link_waddr_o    = NW'(clr_q);
          link_wdata_o    = (clr_q == '0) ? LINK_NULL : LW'(clr_q) + LW'(1);
          status_waddr_o  = NW'(clr_q);
          status_wdata_o  = ST_FREE;
        end
        if (int'(clr_q) < RETIRE_DEPTH) begin
          ring_we_o    = 1'b1;
          ring_waddr_o = RW'(clr_q);
          ring_wdata_o = LINK_NULL;
        end
        if (int'(clr_q) == CLR_LEN - 1) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d   = '0;
          state_d = S_RESULT;
          case (func_e'(in_func_i))
            FN_ALLOC: begin
              if (free_top_q < LINK_NULL) begin
                link_raddr_o   = NW'(free_top_q);
                status_raddr_o = NW'(free_top_q);
                state_d        = S_ALLOC;
              end else begin
                res_d.code = RES_EXHAUSTED;
              end
            end
            FN_DEQ: begin
              ring_raddr_o = pos_q;
              wh_d         = head_q;
              wt_d         = tail_q;
              steps_d      = '0;
              state_d      = S_DQ_RING;
            end
            FN_ENQ: begin
              if (node_in_ok) begin
                mem_we_o        = '{link: 1'b1, status: 1'b1, payload: 1'b1};
                link_waddr_o    = node_idx;
                link_wdata_o    = LINK_NULL;
                status_waddr_o  = node_idx;
                status_wdata_o  = ST_INIT;
                payload_waddr_o = node_idx;
                payload_wdata_o = in_payload_i;
                node_d          = node_idx;
                state_d         = S_ENQ_LINK;
              end
            end
            FN_SET: begin
              if (node_in_ok) begin
                if (in_status_i <= ST_CRASH) begin
                  mem_we_o.status = 1'b1;
                  status_waddr_o  = node_idx;
                  status_wdata_o  = in_status_i;
                  res_d.status    = in_status_i;
                end else begin
                  status_raddr_o = node_idx;
                  state_d        = S_RD_STATUS;
                end
              end
            end
            FN_READ: begin
              if (node_in_ok) begin
                status_raddr_o = node_idx;
                state_d        = S_RD_STATUS;
              end
            end
            FN_FREE: begin
              if (node_in_ok) begin
                mem_we_o.link   = 1'b1;
                mem_we_o.status = 1'b1;
                link_waddr_o    = node_idx;
                link_wdata_o    = free_top_q;
                status_waddr_o  = node_idx;
                status_wdata_o  = ST_FREE;
                free_top_d      = LW'(node_idx);
                res_d.status    = ST_FREE;
              end
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end

      S_ALLOC: begin
        free_top_d   = link_rdata_i;
        res_d.node   = 6'(free_top_q);
        res_d.status = status_rdata_i;
        state_d      = S_RESULT;
      end

      S_RD_STATUS: begin
        res_d.status = status_rdata_i;
        state_d      = S_RESULT;
      end

      // second link write: old tail points at the new node
      S_ENQ_LINK: begin
        mem_we_o.link = 1'b1;
        link_waddr_o  = tail_q;
        link_wdata_o  = LW'(node_q);
        tail_d        = node_q;
        res_d.status  = ST_INIT;
        state_d       = S_RESULT;
      end

      S_DQ_RING: begin
        evict_d        = ring_rdata_i;
        status_raddr_o = NW'(ring_rdata_i);
        state_d        = S_DQ_EVST;
      end

      S_DQ_EVST: begin
        evict_ok_d   = !evict_valid || (status_rdata_i == ST_CONSUMED);
        link_raddr_o = wh_q;
        state_d      = S_DQ_LINK;
      end

      S_DQ_LINK: begin
        if (wh_q == wt_q) begin
          if (!nxt_ok) begin
            head_d     = wh_q;
            tail_d     = wt_q;
            res_d.code = RES_EMPTY;
            state_d    = S_RESULT;
          end else begin
            // lagging tail: catch it up and look again
            wt_d    = nxt_idx;
            steps_d = steps_inc;
            if (steps_inc == STEP_MAX) begin
              head_d     = wh_q;
              tail_d     = nxt_idx;
              res_d.code = RES_EMPTY;
              state_d    = S_RESULT;
            end else begin
              link_raddr_o = wh_q;
            end
          end
        end else if (!nxt_ok) begin
          head_d     = wh_q;
          tail_d     = wt_q;
          res_d.code = RES_EMPTY;
          state_d    = S_RESULT;
        end else begin
          nxt_d          = nxt_idx;
          status_raddr_o = nxt_idx;
          state_d        = S_DQ_STAT;
        end
      end

      S_DQ_STAT: begin
        if (status_rdata_i == ST_INIT) begin
          if (!evict_ok_q) begin
            res_d.code = RES_BLOCKED;
            state_d    = S_RESULT;
          end else begin
            head_d          = nxt_q;
            tail_d          = wt_q;
            mem_we_o.status = 1'b1;
            status_waddr_o  = nxt_q;
            status_wdata_o  = ST_DOING;
            ring_we_o       = 1'b1;
            ring_waddr_o    = pos_q;
            ring_wdata_o    = LW'(wh_q);
            pos_d           = pos_inc;
            if (evict_valid) begin
              mem_we_o.link = 1'b1;
              link_waddr_o  = NW'(evict_q);
              link_wdata_o  = free_top_q;
              free_top_d    = evict_q;
            end
            payload_raddr_o = nxt_q;
            state_d         = S_DQ_FREE;
          end
        end else begin
          // not claimable: step over it
          wh_d    = nxt_q;
          steps_d = steps_inc;
          if (steps_inc == STEP_MAX) begin
            head_d     = nxt_q;
            tail_d     = wt_q;
            res_d.code = RES_EMPTY;
            state_d    = S_RESULT;
          end else begin
            link_raddr_o = nxt_q;
            state_d      = S_DQ_LINK;
          end
        end
      end

      // status port took the DOING write last cycle; evicted node goes FREE now
      S_DQ_FREE: begin
        if (evict_valid) begin
          mem_we_o.status = 1'b1;
          status_waddr_o  = NW'(evict_q);
          status_wdata_o  = ST_FREE;
        end
        res_d.code    = RES_OK;
        res_d.node    = 6'(nxt_q);
        res_d.status  = ST_DOING;
        res_d.payload = payload_rdata_i;
        state_d       = S_RESULT;
      end

      S_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an item was accepted");

  a_ring_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we_o && state_q != S_CLEAR |-> evict_ok_q && state_q == S_DQ_STAT)
    else $error("ring written without a freeable evicted slot");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after result handoff");

  a_head_on_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DQ_STAT && status_rdata_i == ST_INIT && evict_ok_q
    |=> head_q == $past(nxt_q))
    else $error("claimed node did not become the head");
`endif

endmodule
`default_nettype wire

// File: src/linked_list_queue_with_free_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linked_list_queue_with_free_stack_top
// Node-pool queue manager with a free stack and a deferred-free ring.
//
//   channel   dir   tdata (low bit up)                        tuser
//   s_axis    in    node_index, new_status, payload_in        func
//   m_axis    out   node_out, status_out, payload_out         result_code
//
// Free, set, unknown func, alloc on an empty pool: straight to the result;
// alloc, enqueue, read and a set with an unused status code: S_ALLOC,
// S_ENQ_LINK or S_RD_STATUS first. Dequeue: S_DQ_RING, S_DQ_EVST, S_DQ_LINK,
// S_DQ_STAT, S_DQ_FREE, S_DQ_LINK again per tail catch-up, both again per
// skipped node; each step is one registered array read. After reset a
// clearing pass rebuilds the free chain and ring; no item is accepted meanwhile.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module linked_list_queue_with_free_stack_top
  import llq_pkg::*;
#(
  parameter int RETIRE_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,  // node_index[5:0], new_status[8:6], payload_in[40:9]
  input  wire  [2:0]  s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,  // node_out[5:0], status_out[8:6], payload_out[40:9]
  output logic [1:0]  m_axis_tuser   // result_code[1:0]
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int RW = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;

  llq_mem_we_t   mem_we;
  logic [NW-1:0] link_waddr, status_waddr, payload_waddr;
  logic [LW-1:0] link_wdata;
  logic [2:0]    status_wdata;
  logic [31:0]   payload_wdata;
  logic [NW-1:0] link_raddr, status_raddr, payload_raddr;
  logic [LW-1:0] link_rdata;
  logic [2:0]    status_rdata;
  logic [31:0]   payload_rdata;
  logic          ring_we;
  logic [RW-1:0] ring_waddr, ring_raddr;
  logic [LW-1:0] ring_wdata, ring_rdata;

  logic          res_valid, res_ready;
  llq_result_t   res;

  logic          out_valid_q;
  llq_result_t   out_q;

  llq_ctrl #(
    .RETIRE_DEPTH(RETIRE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_func_i      (s_axis_tuser),
    .in_node_i      (s_axis_tdata[5:0]),
    .in_status_i    (s_axis_tdata[8:6]),
    .in_payload_i   (s_axis_tdata[40:9]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_we_o       (mem_we),
    .link_waddr_o   (link_waddr),
    .link_wdata_o   (link_wdata),
    .status_waddr_o (status_waddr),
    .status_wdata_o (status_wdata),
    .payload_waddr_o(payload_waddr),
    .payload_wdata_o(payload_wdata),
    .link_raddr_o   (link_raddr),
    .status_raddr_o (status_raddr),
    .payload_raddr_o(payload_raddr),
    .link_rdata_i   (link_rdata),
    .status_rdata_i (status_rdata),
    .payload_rdata_i(payload_rdata),
    .ring_we_o      (ring_we),
    .ring_waddr_o   (ring_waddr),
    .ring_wdata_o   (ring_wdata),
    .ring_raddr_o   (ring_raddr),
    .ring_rdata_i   (ring_rdata)
  );

  llq_node_mem u_node_mem (
    .clk_i          (clk_i),
    .we_i           (mem_we),
    .link_waddr_i   (link_waddr),
    .link_wdata_i   (link_wdata),
    .status_waddr_i (status_waddr),
    .status_wdata_i (status_wdata),
    .payload_waddr_i(payload_waddr),
    .payload_wdata_i(payload_wdata),
    .link_raddr_i   (link_raddr),
    .status_raddr_i (status_raddr),
    .payload_raddr_i(payload_raddr),
    .link_rdata_o   (link_rdata),
    .status_rdata_o (status_rdata),
    .payload_rdata_o(payload_rdata)
  );

  llq_ring_mem #(
    .RETIRE_DEPTH(RETIRE_DEPTH)
  ) u_ring_mem (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  // output register: one result item held until the sink takes it
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.code;
  assign m_axis_tdata  = {7'b0, out_q.payload, out_q.status, out_q.node};

endmodule
`default_nettype wire

// File: sim/tb_linked_list_queue_with_free_stack_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_list_queue_with_free_stack_top
// Self-checking bench for the node-pool queue manager. A shadow copy of the
// node pool, free stack, queue and retire ring predicts every result. Runs
// directed ops, pool exhaustion, ring blocking, a long output stall and a
// long random mix of alloc/enqueue/dequeue/status flows with stream idling.
// ----------------------------------------------------------------------------
module tb_linked_list_queue_with_free_stack_top
  import llq_pkg::*;
();

  localparam int RETIRE_DEPTH  = 16;
  localparam int WALK_LIMIT    = 2 * POOL_NODES + 2;
  localparam logic [6:0] LINK_NULL = 7'd64;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // node_index[5:0], new_status[8:6], payload_in[40:9]
  logic [2:0]  s_axis_tuser = '0;  // func[2:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [47:0] m_axis_tdata;       // node_out[5:0], status_out[8:6], payload_out[40:9]
  wire  [1:0]  m_axis_tuser;       // result_code[1:0]

  linked_list_queue_with_free_stack_top #(
    .RETIRE_DEPTH(RETIRE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pool model
  logic [6:0]  link_q [POOL_NODES];
  logic [2:0]  stat_q [POOL_NODES];
  logic [31:0] pay_q  [POOL_NODES];
  bit          pay_set[POOL_NODES];
  logic [5:0]  head_q;
  logic [5:0]  tail_q;
  logic [6:0]  ftop_q;
  logic [6:0]  ring_q [RETIRE_DEPTH];
  logic [3:0]  rpos_q;

  llq_result_t pending_results[$];
  logic [5:0]  owned_nodes[$];
  logic [5:0]  claimed_nodes[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  bit  hold_rx_req = 1'b0;

  function automatic void pool_reset();
    for (int i = 0; i < POOL_NODES; i++) begin
      link_q[i]  = (i + 1 < POOL_NODES) ? 7'(i + 1) : LINK_NULL;
      stat_q[i]  = ST_FREE;
      pay_q[i]   = '0;
      pay_set[i] = 1'b0;
    end
    link_q[0] = LINK_NULL;
    head_q = '0;
    tail_q = '0;
    ftop_q = 7'd1;
    for (int i = 0; i < RETIRE_DEPTH; i++) ring_q[i] = LINK_NULL;
    rpos_q = '0;
  endfunction

  function automatic void free_push(logic [5:0] n);
    stat_q[n] = ST_FREE;
    link_q[n] = ftop_q;
    ftop_q    = {1'b0, n};
  endfunction

  function automatic llq_result_t dequeue_result();
    llq_result_t r;
    logic [5:0]  h;
    logic [5:0]  t;
    logic [6:0]  nxt;
    logic [6:0]  ev;
    int          i;
    r = '0;
    h = head_q;
    t = tail_q;
    for (i = 0; i < WALK_LIMIT; i++) begin
      nxt = link_q[h];
      if (h == t) begin
        if (nxt[6]) break;
        t = nxt[5:0];  // tail lagging behind
        continue;
      end
      if (nxt[6]) break;  // broken chain
      if (stat_q[nxt[5:0]] == ST_INIT) begin
        ev = ring_q[rpos_q];
        if (!ev[6] && stat_q[ev[5:0]] != ST_CONSUMED) begin
          r.code = RES_BLOCKED;  // nothing changes, walk dropped
          return r;
        end
        head_q = nxt[5:0];
        tail_q = t;
        stat_q[nxt[5:0]] = ST_DOING;
        if (!ev[6]) free_push(ev[5:0]);
        ring_q[rpos_q] = {1'b0, h};
        rpos_q = rpos_q + 4'd1;
        r.code    = RES_OK;
        r.node    = nxt[5:0];
        r.status  = ST_DOING;
        r.payload = pay_q[nxt[5:0]];
        return r;
      end
      h = nxt[5:0];
    end
    // advances made by a failed walk stay
    head_q = h;
    tail_q = t;
    r.code = RES_EMPTY;
    return r;
  endfunction

  function automatic llq_result_t queue_op_result(logic [2:0] f, logic [5:0] n,
                                                  logic [2:0] s, logic [31:0] p);
    llq_result_t r;
    r = '0;
    r.code = RES_OK;
    case (f)
      FN_ALLOC: begin
        if (ftop_q[6]) begin
          r.code = RES_EXHAUSTED;
        end else begin
          r.node   = ftop_q[5:0];
          r.status = stat_q[ftop_q[5:0]];
          ftop_q   = link_q[ftop_q[5:0]];
        end
      end
      FN_DEQ: r = dequeue_result();
      FN_ENQ: begin
        pay_q[n]   = p;
        pay_set[n] = 1'b1;
        link_q[n]  = LINK_NULL;
        stat_q[n]  = ST_INIT;
        link_q[tail_q] = {1'b0, n};  // self loop when n is the tail
        tail_q   = n;
        r.status = ST_INIT;
      end
      FN_SET: begin
        if (s <= ST_CRASH) stat_q[n] = s;
        r.status = stat_q[n];
      end
      FN_READ: r.status = stat_q[n];
      FN_FREE: begin
        free_push(n);
        r.status = ST_FREE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t: %s got %h expected %h", $realtime, field, got, want);
    err_cnt++;
  endtask

  // one item onto the input stream; returns the predicted result
  task automatic send_item(input logic [2:0] f, input logic [5:0] n, input logic [2:0] s,
                           input logic [31:0] p, output llq_result_t r);
    int gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, p, s, n};
    s_axis_tuser  = f;
    do @(posedge clk_i); while (!s_axis_tready);
    r = queue_op_result(f, n, s, p);
    pending_results.push_back(r);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    llq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, m_axis_tuser}, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.code)
          report_mismatch("result_code", {30'd0, m_axis_tuser}, {30'd0, want.code});
        if (m_axis_tdata[5:0] !== want.node)
          report_mismatch("node_out", {26'd0, m_axis_tdata[5:0]}, {26'd0, want.node});
        if (m_axis_tdata[8:6] !== want.status)
          report_mismatch("status_out", {29'd0, m_axis_tdata[8:6]}, {29'd0, want.status});
        if (m_axis_tdata[40:9] !== want.payload)
          report_mismatch("payload_out", m_axis_tdata[40:9], want.payload);
      end
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx_req) begin
        m_axis_tready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk_i);
        hold_rx_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly well-formed node lifecycles, a little noise
  task automatic run_workflow(int count);
    llq_result_t r;
    int          pick;
    int          idx;
    logic [5:0]  n;
    logic [2:0]  s;
    logic [6:0]  ev;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 46 && pick >= 8) begin
        if ((pick < 26 && owned_nodes.size() < 6) || owned_nodes.size() == 0) begin
          send_item(FN_ALLOC, 6'($urandom), 3'($urandom), $urandom, r);
          if (r.code == RES_OK) owned_nodes.push_back(r.node);
        end else begin
          idx = $urandom_range(0, owned_nodes.size() - 1);
          n = owned_nodes[idx];
          owned_nodes.delete(idx);
          send_item(FN_ENQ, n, 3'($urandom), $urandom, r);
        end
      end else if (pick >= 46 && pick < 66) begin
        send_item(FN_DEQ, 6'($urandom), 3'($urandom), $urandom, r);
        if (r.code == RES_OK) claimed_nodes.push_back(r.node);
      end else if (pick >= 66 && pick < 88) begin
        ev = ring_q[rpos_q];
        if (claimed_nodes.size() != 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, claimed_nodes.size() - 1);
          n = claimed_nodes[idx];
          claimed_nodes.delete(idx);
          if ($urandom_range(0, 4) == 0) begin
            s = $urandom_range(0, 1) ? ST_DONE : ST_CRASH;
            send_item(FN_SET, n, s, $urandom, r);
          end
          send_item(FN_SET, n, ST_CONSUMED, $urandom, r);
        end else if (!ev[6]) begin
          // unstick the ring slot due for eviction
          send_item(FN_SET, ev[5:0], ST_CONSUMED, $urandom, r);
        end else begin
          send_item(FN_READ, 6'($urandom), 3'($urandom), $urandom, r);
        end
      end else if (pick >= 88 && pick < 94) begin
        send_item(FN_READ, 6'($urandom), 3'($urandom), $urandom, r);
      end else if (pick >= 94) begin
        if (owned_nodes.size() != 0) begin
          idx = $urandom_range(0, owned_nodes.size() - 1);
          n = owned_nodes[idx];
          owned_nodes.delete(idx);
          send_item(FN_FREE, n, 3'($urandom), $urandom, r);
        end else begin
          send_item(FN_ALLOC, 6'($urandom), 3'($urandom), $urandom, r);
          if (r.code == RES_OK) owned_nodes.push_back(r.node);
        end
      end else begin
        n = 6'($urandom);
        s = 3'($urandom_range(0, 7));
        // a node made INIT by set must already hold a payload
        if (s == ST_INIT && !pay_set[n]) s = ST_DONE;
        send_item(3'($urandom_range(0, 7)), n, s, $urandom, r);
      end
    end
  endtask

  task automatic test_directed_ops();
    llq_result_t r;
    send_item(FN_READ, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_READ, 6'd63, 3'd7, 32'hFFFF_FFFF, r);
    send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);  // empty queue
    send_item(FN_ALLOC, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_ALLOC, 6'd63, 3'd7, 32'h0, r);
    send_item(FN_ENQ, 6'd1, 3'd0, 32'hFFFF_FFFF, r);
    send_item(FN_ENQ, 6'd2, 3'd7, 32'h0000_0000, r);
    send_item(FN_SET, 6'd2, ST_DONE, 32'h0, r);
    send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);  // skips a DONE node, then empty
    send_item(FN_SET, 6'd2, 3'd7, 32'h0, r);  // out-of-range status ignored
    send_item(FN_SET, 6'd63, ST_CRASH, 32'h0, r);
    send_item(FN_READ, 6'd63, 3'd0, 32'h0, r);
    send_item(FN_SET, 6'd63, ST_FREE, 32'h0, r);
    send_item(FN_SET, 6'd1, ST_CONSUMED, 32'h0, r);
    send_item(3'd6, 6'd63, 3'd7, 32'hFFFF_FFFF, r);
    send_item(3'd7, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_ALLOC, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_ENQ, 6'd3, 3'd0, 32'h5A5A_A5A5, r);
    send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);
    send_item(FN_SET, 6'd3, ST_CONSUMED, 32'h0, r);
    send_item(FN_FREE, 6'd1, 3'd0, 32'h0, r);
  endtask

  task automatic test_pool_exhaust();
    llq_result_t r;
    logic [5:0]  taken[$];
    for (int i = 0; i <= POOL_NODES; i++) begin
      send_item(FN_ALLOC, 6'($urandom), 3'($urandom), $urandom, r);
      if (r.code != RES_OK) break;
      taken.push_back(r.node);
    end
    while (taken.size() != 0) send_item(FN_FREE, taken.pop_back(), 3'd0, $urandom, r);
  endtask

  task automatic test_deferred_free_block();
    llq_result_t r;
    for (int i = 0; i < RETIRE_DEPTH + 4; i++) begin
      send_item(FN_ALLOC, 6'd0, 3'd0, 32'h0, r);
      if (r.code == RES_OK) send_item(FN_ENQ, r.node, 3'd0, $urandom, r);
      send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);
      if (r.code == RES_BLOCKED) break;
      if (r.code == RES_OK) claimed_nodes.push_back(r.node);
    end
    for (int i = 0; i < RETIRE_DEPTH; i++)
      if (!ring_q[i][6]) send_item(FN_SET, ring_q[i][5:0], ST_CONSUMED, $urandom, r);
    send_item(FN_DEQ, 6'd0, 3'd0, 32'h0, r);
    if (r.code == RES_OK) claimed_nodes.push_back(r.node);
  endtask

  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    hold_rx_req = 1'b1;
    run_workflow(40);
  endtask

  task automatic test_random();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_workflow(1100);
    // closing stretch at full rate
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_workflow(200);
  endtask

  initial begin
    pool_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    wait_drain();
    test_pool_exhaust();
    test_deferred_free_block();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results missing", 32'(pending_results.size()), '0);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
